// ===== rtl/gn3_pkg.sv =====
package gn3_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW     = $clog2(TABLE_SIZE);
  localparam int FRAC_BITS  = 16;
  localparam int GRAD_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int OUT_W      = 18;
  localparam int DOT_W      = 20;
  localparam int MUL_W      = 24;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int GRAM_W     = 3 * GRAD_BITS;

  typedef enum logic [1:0] {
    ACT_EVAL = 2'd0,
    ACT_PERM = 2'd1,
    ACT_GRAD = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HZ,
    S_HY,
    S_HX,
    S_GRD,
    S_DOT,
    S_FADE,
    S_BLEND,
    S_OUT
  } state_e;

endpackage

// ===== rtl/gn3_ram.sv =====
module gn3_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gradient_noise_3d.sv =====
// 3-D gradient noise. Load items (action 1, 2) write one table entry and leave
// busy low, so one may follow every cycle. An evaluate item holds busy high, and
// its result appears on done_o/noise_value_o for one cycle straight after busy
// falls; the receiver cannot stall it. The busy time is set by the 22 dependent
// table reads (14 permutation, 8 gradient), made one at a time on each table's
// read port, and by the one shared 24x24 multiplier that forms the 24 dot-product
// terms, 12 fade products and 7 blends in turn.
module gradient_noise_3d (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [gn3_pkg::COORD_W-1:0]  coord_z_i,
  input  logic [gn3_pkg::TBL_AW-1:0]          table_index_i,
  input  logic [gn3_pkg::TBL_AW-1:0]          perm_value_i,
  input  logic signed [gn3_pkg::GRAD_BITS-1:0] grad_x_i,
  input  logic signed [gn3_pkg::GRAD_BITS-1:0] grad_y_i,
  input  logic signed [gn3_pkg::GRAD_BITS-1:0] grad_z_i,
  output logic                                done_o,
  output logic signed [gn3_pkg::OUT_W-1:0]    noise_value_o
);
  import gn3_pkg::*;

  localparam logic signed [MUL_W-1:0] ONE_S = MUL_W'(1 << FRAC_BITS);

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] cor_q;
  logic [1:0] axis_q;
  logic       take;

  logic [TBL_AW-1:0]    xi_q, yi_q, zi_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q, fz_q;
  logic [TBL_AW-1:0]    hz_q [2];
  logic [TBL_AW-1:0]    hy_q [4];
  logic [TBL_AW-1:0]    hx_q [8];
  logic signed [DOT_W-1:0] d_q [8];
  logic [FRAC_BITS:0]   w_q [3];
  logic signed [MUL_W-1:0]  b_q;
  logic signed [35:0]       acc_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                     done_q, done_d;
  logic signed [OUT_W-1:0]  noise_q, noise_d;

  logic              p_re, g_re;
  logic [TBL_AW-1:0] p_raddr, g_raddr;
  logic [TBL_AW-1:0] p_rdata;
  logic [GRAM_W-1:0] g_rdata;
  logic [3:0]        pidx;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_sh;
  logic [FRAC_BITS-1:0]     t_sel;
  logic signed [MUL_W-1:0]  a_val;
  logic signed [DOT_W-1:0]  lo, hi;
  logic [FRAC_BITS:0]       wsel;
  logic [2:0]               dst;
  logic signed [35:0]       dot_sum;

  assign take = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign pidx = cnt_q - 4'd1;
  assign prod_sh = prod_q >>> FRAC_BITS;

  gn3_ram #(.Width(TBL_AW), .Depth(TABLE_SIZE)) u_perm (
    .clk_i  (clk_i),
    .we_i   (take && action_i == ACT_PERM),
    .waddr_i(table_index_i),
    .wdata_i(perm_value_i),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  gn3_ram #(.Width(GRAM_W), .Depth(TABLE_SIZE)) u_grad (
    .clk_i  (clk_i),
    .we_i   (take && action_i == ACT_GRAD),
    .waddr_i(table_index_i),
    .wdata_i({grad_x_i, grad_y_i, grad_z_i}),
    .re_i   (g_re),
    .raddr_i(g_raddr),
    .rdata_o(g_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 4'd1;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (take && action_i == ACT_EVAL) begin
          state_d = S_HZ;
        end
      end
      S_HZ: begin
        if (cnt_q == 4'd2) begin
          state_d = S_HY;
          cnt_d   = '0;
        end
      end
      S_HY: begin
        if (cnt_q == 4'd4) begin
          state_d = S_HX;
          cnt_d   = '0;
        end
      end
      S_HX: begin
        if (cnt_q == 4'd8) begin
          state_d = S_GRD;
          cnt_d   = '0;
        end
      end
      S_GRD: begin
        state_d = S_DOT;
        cnt_d   = '0;
      end
      S_DOT: begin
        if (cnt_q == 4'd3) begin
          state_d = (cor_q == 3'd7) ? S_FADE : S_GRD;
          cnt_d   = '0;
        end
      end
      S_FADE: begin
        if (cnt_q == 4'd4) begin
          cnt_d = '0;
          if (axis_q == 2'd2) begin
            state_d = S_BLEND;
          end
        end
      end
      S_BLEND: begin
        if (cnt_q == 4'd13) begin
          state_d = S_OUT;
          cnt_d   = '0;
        end
      end
      S_OUT: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // datapath control
  always_comb begin
    p_re    = 1'b0;
    p_raddr = '0;
    g_re    = 1'b0;
    g_raddr = hx_q[cor_q];
    mul_a   = '0;
    mul_b   = '0;
    case (axis_q)
      2'd0:    t_sel = fx_q;
      2'd1:    t_sel = fy_q;
      default: t_sel = fz_q;
    endcase
    a_val = $signed({{(MUL_W-FRAC_BITS){1'b0}}, t_sel}) * MUL_W'(6) - ONE_S * MUL_W'(15);
    case (cnt_q[3:1])
      3'd0: begin lo = d_q[0]; hi = d_q[1]; wsel = w_q[0]; dst = 3'd0; end
      3'd1: begin lo = d_q[2]; hi = d_q[3]; wsel = w_q[0]; dst = 3'd2; end
      3'd2: begin lo = d_q[4]; hi = d_q[5]; wsel = w_q[0]; dst = 3'd4; end
      3'd3: begin lo = d_q[6]; hi = d_q[7]; wsel = w_q[0]; dst = 3'd6; end
      3'd4: begin lo = d_q[0]; hi = d_q[2]; wsel = w_q[1]; dst = 3'd0; end
      3'd5: begin lo = d_q[4]; hi = d_q[6]; wsel = w_q[1]; dst = 3'd4; end
      3'd6: begin lo = d_q[0]; hi = d_q[4]; wsel = w_q[2]; dst = 3'd0; end
      default: begin lo = d_q[0]; hi = d_q[0]; wsel = '0; dst = 3'd0; end
    endcase
    case (state_q)
      S_HZ: begin
        p_re    = (cnt_q < 4'd2);
        p_raddr = cnt_q[0] ? zi_q + TBL_AW'(1) : zi_q;
      end
      S_HY: begin
        p_re    = (cnt_q < 4'd4);
        p_raddr = (cnt_q[0] ? yi_q + TBL_AW'(1) : yi_q) + hz_q[cnt_q[1]];
      end
      S_HX: begin
        p_re    = (cnt_q < 4'd8);
        p_raddr = (cnt_q[0] ? xi_q + TBL_AW'(1) : xi_q) + hy_q[cnt_q[2:1]];
      end
      S_GRD: begin
        g_re = 1'b1;
      end
      S_DOT: begin
        case (cnt_q[1:0])
          2'd0: begin
            mul_a = MUL_W'($signed(g_rdata[3*GRAD_BITS-1:2*GRAD_BITS]));
            mul_b = MUL_W'($signed({cor_q[0], fx_q}));
          end
          2'd1: begin
            mul_a = MUL_W'($signed(g_rdata[2*GRAD_BITS-1:GRAD_BITS]));
            mul_b = MUL_W'($signed({cor_q[1], fy_q}));
          end
          2'd2: begin
            mul_a = MUL_W'($signed(g_rdata[GRAD_BITS-1:0]));
            mul_b = MUL_W'($signed({cor_q[2], fz_q}));
          end
          default: ;
        endcase
      end
      S_FADE: begin
        case (cnt_q[2:0])
          3'd0: begin
            mul_a = a_val;
            mul_b = $signed({{(MUL_W-FRAC_BITS){1'b0}}, t_sel});
          end
          3'd1: begin
            mul_a = $signed({{(MUL_W-FRAC_BITS){1'b0}}, t_sel});
            mul_b = $signed({{(MUL_W-FRAC_BITS){1'b0}}, t_sel});
          end
          3'd2: begin
            mul_a = prod_sh[MUL_W-1:0];
            mul_b = $signed({{(MUL_W-FRAC_BITS){1'b0}}, t_sel});
          end
          3'd3: begin
            mul_a = b_q;
            mul_b = prod_sh[MUL_W-1:0];
          end
          default: ;
        endcase
      end
      S_BLEND: begin
        mul_a = $signed({{(MUL_W-FRAC_BITS-1){1'b0}}, wsel});
        mul_b = MUL_W'(hi) - MUL_W'(lo);
      end
      default: ;
    endcase
  end

  assign dot_sum = acc_q + prod_q[35:0];

  always_comb begin
    done_d  = (state_q == S_OUT);
    noise_d = noise_q;
    if (state_q == S_OUT) begin
      if (d_q[0] > DOT_W'(131071)) begin
        noise_d = OUT_W'(131071);
      end else if (d_q[0] < -DOT_W'(131072)) begin
        noise_d = -OUT_W'(131072);
      end else begin
        noise_d = d_q[0][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cor_q   <= '0;
      axis_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (state_q == S_IDLE) begin
        cor_q  <= '0;
        axis_q <= '0;
      end
      if (state_q == S_DOT && cnt_q == 4'd3) begin
        cor_q <= cor_q + 3'd1;
      end
      if (state_q == S_FADE && cnt_q == 4'd4) begin
        axis_q <= axis_q + 2'd1;
      end
    end
  end

  logic signed [31:0] fv;
  assign fv = prod_sh[31:0];

  always_ff @(posedge clk_i) begin
    prod_q  <= mul_a * mul_b;
    noise_q <= noise_d;
    if (take) begin
      xi_q <= coord_x_i[FRAC_BITS +: TBL_AW];
      yi_q <= coord_y_i[FRAC_BITS +: TBL_AW];
      zi_q <= coord_z_i[FRAC_BITS +: TBL_AW];
      fx_q <= coord_x_i[FRAC_BITS-1:0];
      fy_q <= coord_y_i[FRAC_BITS-1:0];
      fz_q <= coord_z_i[FRAC_BITS-1:0];
    end
    if (state_q == S_HZ && cnt_q != 4'd0) begin
      hz_q[pidx[0]] <= p_rdata;
    end
    if (state_q == S_HY && cnt_q != 4'd0) begin
      hy_q[pidx[1:0]] <= p_rdata;
    end
    if (state_q == S_HX && cnt_q != 4'd0) begin
      hx_q[pidx[2:0]] <= p_rdata;
    end
    if (state_q == S_DOT) begin
      if (cnt_q == 4'd1) begin
        acc_q <= prod_q[35:0];
      end else if (cnt_q == 4'd2) begin
        acc_q <= dot_sum;
      end else if (cnt_q == 4'd3) begin
        d_q[cor_q] <= DOT_W'(dot_sum >>> (GRAD_BITS - 1));
      end
    end
    if (state_q == S_FADE) begin
      if (cnt_q == 4'd1) begin
        b_q <= prod_sh[MUL_W-1:0] + ONE_S * MUL_W'(10);
      end else if (cnt_q == 4'd4) begin
        if (fv < 0) begin
          w_q[axis_q] <= '0;
        end else if (fv > 32'(1 << FRAC_BITS)) begin
          w_q[axis_q] <= (FRAC_BITS+1)'(1 << FRAC_BITS);
        end else begin
          w_q[axis_q] <= fv[FRAC_BITS:0];
        end
      end
    end
    if (state_q == S_BLEND && cnt_q[0]) begin
      d_q[dst] <= DOT_W'(MUL_W'(lo) + prod_sh[MUL_W-1:0]);
    end
  end

  assign done_o        = done_q;
  assign noise_value_o = noise_q;

endmodule

// ===== rtl/gn3_checker.sv =====
module gn3_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [1:0] action_i,
  input logic       done_o
);
  import gn3_pkg::*;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i == ACT_EVAL) |=> busy)
    else $error("evaluate transfer did not raise busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && action_i != ACT_EVAL) |=> (!busy && !done_o))
    else $error("load transfer raised busy or gave a result");

endmodule

bind gradient_noise_3d gn3_checker u_gn3_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .action_i(action_i),
  .done_o  (done_o)
);

// ===== test/tb_gradient_noise_3d.sv =====
module tb_gradient_noise_3d;
  import gn3_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam longint ONE = 64'sd1 << FRAC_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action_i = ACT_EVAL;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [7:0] table_index_i = '0, perm_value_i = '0;
  logic signed [15:0] grad_x_i = '0, grad_y_i = '0, grad_z_i = '0;
  logic done_o;
  logic signed [17:0] noise_value_o;

  logic [7:0] perm_tbl [256];
  logic signed [15:0] gxt [256], gyt [256], gzt [256];
  logic signed [17:0] noise_expected [$];
  int mismatches = 0;
  bit no_gaps = 0;

  gradient_noise_3d dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .table_index_i, .perm_value_i, .grad_x_i, .grad_y_i, .grad_z_i, .done_o,
    .noise_value_o
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint fade_q(longint t);
    longint a, b, t2, t3, f;
    a = 6 * t - 15 * ONE;
    b = ((a * t) >>> FRAC_BITS) + 10 * ONE;
    t2 = (t * t) >>> FRAC_BITS;
    t3 = (t2 * t) >>> FRAC_BITS;
    f = (b * t3) >>> FRAC_BITS;
    if (f < 0) f = 0;
    if (f > ONE) f = ONE;
    return f;
  endfunction

  function automatic longint lerp_q(longint lo, longint hi, longint f);
    return lo + ((f * (hi - lo)) >>> FRAC_BITS);
  endfunction

  function automatic longint corner_grad_dot(logic [7:0] cx, logic [7:0] cy, logic [7:0] cz,
                                             longint ox, longint oy, longint oz);
    logic [7:0] h;
    longint d;
    h = perm_tbl[cz];
    h = perm_tbl[8'(cy + h)];
    h = perm_tbl[8'(cx + h)];
    d = longint'(gxt[h]) * ox + longint'(gyt[h]) * oy + longint'(gzt[h]) * oz;
    return d >>> (GRAD_BITS - 1);
  endfunction

  function automatic logic signed [17:0] noise_at(logic [31:0] x, logic [31:0] y,
                                                  logic [31:0] z);
    logic [7:0] x0, y0, z0, x1, y1, z1;
    longint fx, fy, fz, gx, gy, gz, wx, wy, wz, s, t, u, v, r;
    x0 = x[23:16]; y0 = y[23:16]; z0 = z[23:16];
    x1 = x0 + 8'd1; y1 = y0 + 8'd1; z1 = z0 + 8'd1;
    fx = longint'(x[15:0]); fy = longint'(y[15:0]); fz = longint'(z[15:0]);
    gx = fx - ONE; gy = fy - ONE; gz = fz - ONE;
    wx = fade_q(fx); wy = fade_q(fy); wz = fade_q(fz);
    s = lerp_q(corner_grad_dot(x0, y0, z0, fx, fy, fz),
               corner_grad_dot(x1, y0, z0, gx, fy, fz), wx);
    t = lerp_q(corner_grad_dot(x0, y1, z0, fx, gy, fz),
               corner_grad_dot(x1, y1, z0, gx, gy, fz), wx);
    u = lerp_q(corner_grad_dot(x0, y0, z1, fx, fy, gz),
               corner_grad_dot(x1, y0, z1, gx, fy, gz), wx);
    v = lerp_q(corner_grad_dot(x0, y1, z1, fx, gy, gz),
               corner_grad_dot(x1, y1, z1, gx, gy, gz), wx);
    r = lerp_q(lerp_q(s, t, wy), lerp_q(u, v, wy), wz);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return 18'(r);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 19);
    if (no_gaps || p < 12) return 0;
    if (p < 18) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(logic [1:0] act, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [7:0] idx, logic [7:0] pv,
                           logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    int gap;
    action_i <= act;
    coord_x_i <= x; coord_y_i <= y; coord_z_i <= z;
    table_index_i <= idx; perm_value_i <= pv;
    grad_x_i <= gx; grad_y_i <= gy; grad_z_i <= gz;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    case (act)
      ACT_EVAL: noise_expected.push_back(noise_at(x, y, z));
      ACT_PERM: perm_tbl[idx] = pv;
      ACT_GRAD: begin
        gxt[idx] = gx; gyt[idx] = gy; gzt[idx] = gz;
      end
      default: ;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(ACT_EVAL, x, y, z, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic load_perm(logic [7:0] idx, logic [7:0] pv);
    send_item(ACT_PERM, $urandom, $urandom, $urandom, idx, pv, 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic load_grad(logic [7:0] idx, logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    send_item(ACT_GRAD, $urandom, $urandom, $urandom, idx, 8'($urandom), gx, gy, gz);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (noise_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected noise result %0d", noise_value_o);
      end else begin
        if (noise_value_o !== noise_expected[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("noise mismatch: expected %0d, got %0d", noise_expected[0],
                     noise_value_o);
        end
        void'(noise_expected.pop_front());
      end
    end
  end

  // every entry written before any evaluate, so no read of an unwritten entry
  task automatic test_table_fill();
    no_gaps = 1;
    for (int i = 0; i < 256; i++) load_perm(8'(i), 8'($urandom));
    no_gaps = 0;
    for (int i = 0; i < 256; i++)
      load_grad(8'(i), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic test_corner_cases();
    load_grad(8'h00, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    load_grad(8'hFF, 16'h8000, 16'h8000, 16'h8000);
    load_perm(8'h00, 8'hFF);
    load_perm(8'hFF, 8'h00);
    eval_at(32'h0, 32'h0, 32'h0);
    eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_at(32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_0000);
    eval_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    eval_at(32'h00FF_0001, 32'hFF00_FFFF, 32'h0100_7FFF);
    eval_at(32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_C000);
  endtask

  task automatic test_ignored_action();
    send_item(ACT_UNUSED, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
    eval_at($urandom, $urandom, $urandom);
    send_item(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1);
  endtask

  task automatic test_drain_pause();
    start <= 1'b0;
    wait (noise_expected.size() == 0);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic test_random_mix(int n, bit extreme);
    logic [31:0] c [3];
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (i % 200 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      if (k < 20) begin
        if (extreme)
          load_grad(8'($urandom), $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                    $urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                    $urandom_range(0, 1) ? 16'h7FFF : 16'h8000);
        else load_grad(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (k < 32) load_perm(8'($urandom), 8'($urandom));
      else if (k < 34) send_item(ACT_UNUSED, $urandom, $urandom, $urandom, 8'($urandom),
                                 8'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom));
      else begin
        for (int j = 0; j < 3; j++) begin
          case ($urandom_range(0, 3))
            0: c[j] = $urandom;
            1: c[j] = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            2: c[j] = {16'($urandom), $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
            default: c[j] = {16'($urandom), 16'($urandom_range(0, 15) << 12)};
          endcase
        end
        eval_at(c[0], c[1], c[2]);
      end
    end
    no_gaps = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_table_fill();
    test_corner_cases();
    test_ignored_action();
    test_random_mix(800, 0);
    test_drain_pause();
    test_random_mix(200, 1);
    test_random_mix(200, 0);
    start <= 1'b0;
    wait (noise_expected.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
